// ----- rtl/m4fx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4fx_pkg: shared types for the 4x4 fixed-point matrix unit
// Request codes, sequencer states and the control word that travels from the
// issue sequencer into the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package m4fx_pkg;

  // default fixed-point format (Q16.16)
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_WR_A  = 3'd0,
    REQ_WR_B  = 3'd1,
    REQ_MUL   = 3'd2,
    REQ_ADD   = 3'd3,
    REQ_SCALE = 3'd4,
    REQ_VEC   = 3'd5,
    REQ_RD_A  = 3'd6
  } req_t;

  // issue sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // one issue slot: which operand pieces to multiply and where it sits
  typedef struct packed {
    logic       valid;
    logic       ka;          // piece of operand a
    logic       kb;          // piece of operand b
    logic       raw;         // pass a (+ b) through, no multiply, no shift
    logic       add_b;       // raw path also adds operand b
    logic       first_part;
    logic       last_part;
    logic       first_term;
    logic       last_term;
    logic [3:0] elem;
    logic       last_elem;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic busy;              // a slot is still in flight
    logic hold;              // output word stalled, freeze everything
  } stat_t;

endpackage

// ----- rtl/m4fx_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4fx_mac: shared multiply-accumulate datapath
// Multiplies operand pieces, assembles exact products, shifts out the fraction,
// sums the terms of one element, saturates and holds the result word.
// ----------------------------------------------------------------------------
module m4fx_mac #(
  parameter int DATA_WIDTH = m4fx_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m4fx_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  m4fx_pkg::ctrl_t       r_ctrl,
  input  logic [DATA_WIDTH-1:0] rd_a,
  input  logic [DATA_WIDTH-1:0] rd_b,
  output m4fx_pkg::stat_t       stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_index,
  output logic [31:0]           out_value,
  output logic                  out_last
);

  localparam int DW     = DATA_WIDTH;
  localparam int NP     = (DW > 32) ? 2 : 1;
  localparam int PW     = (DW + NP - 1) / NP;
  localparam int XW     = NP * PW + 1;
  localparam int MUL_W  = 2 * PW + 2;
  localparam int PROD_W = 2 * NP * PW + 4;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SH_W   = $clog2(2 * PW + 1);
  localparam int OV_W   = (DW > 32) ? DW : 32;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [DW-1:0] r;
    priority if (v > ACC_MAX) begin
      r = ACC_MAX[DW-1:0];
    end else if (v < ACC_MIN) begin
      r = ACC_MIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  logic en;

  // operand pieces: low piece unsigned, top piece signed
  logic [XW-1:0]         a_ext, b_ext;
  logic signed [PW:0]    pa, pb;
  logic signed [MUL_W-1:0] mul_res, raw_sum;
  logic [SH_W-1:0]       sh_sel;

  // stage M
  m4fx_pkg::ctrl_t         m_ctrl;
  logic signed [MUL_W-1:0] pp;
  logic [SH_W-1:0]         m_sh;

  // stage P
  m4fx_pkg::ctrl_t          p_ctrl;
  logic signed [PROD_W-1:0] prod_acc;
  logic signed [PROD_W-1:0] pp_shifted;

  // stage T
  logic                     t_done;
  logic [3:0]               t_elem;
  logic                     t_last;
  logic signed [ACC_W-1:0]  elem_acc;
  logic signed [PROD_W-1:0] term;

  logic [DW-1:0]   sat_res;
  logic [OV_W-1:0] ov_ext;

  assign en        = !(out_valid && out_stall);
  assign stat.hold = !en;
  assign stat.busy = m_ctrl.valid || p_ctrl.valid || t_done;

  // pick the operand pieces for this slot
  assign a_ext = {{(XW-DW){rd_a[DW-1]}}, rd_a};
  assign b_ext = {{(XW-DW){rd_b[DW-1]}}, rd_b};

  always_comb begin
    if (r_ctrl.ka) begin
      pa = a_ext[XW-1 -: PW+1];
    end else begin
      pa = {(NP == 1) ? a_ext[XW-1] : 1'b0, a_ext[PW-1:0]};
    end
    if (r_ctrl.kb) begin
      pb = b_ext[XW-1 -: PW+1];
    end else begin
      pb = {(NP == 1) ? b_ext[XW-1] : 1'b0, b_ext[PW-1:0]};
    end
    priority if (r_ctrl.ka && r_ctrl.kb) begin
      sh_sel = SH_W'(2 * PW);
    end else if (r_ctrl.ka || r_ctrl.kb) begin
      sh_sel = SH_W'(PW);
    end else begin
      sh_sel = '0;
    end
  end

  assign mul_res = pa * pb;
  assign raw_sum = {{(MUL_W-DW){rd_a[DW-1]}}, rd_a}
                 + (r_ctrl.add_b ? {{(MUL_W-DW){rd_b[DW-1]}}, rd_b} : MUL_W'(0));

  assign pp_shifted = {{(PROD_W-MUL_W){pp[MUL_W-1]}}, pp} <<< m_sh;
  assign term       = p_ctrl.raw ? prod_acc : (prod_acc >>> FRAC_BITS);

  assign sat_res = sat_out(elem_acc);
  assign ov_ext  = OV_W'(sat_res);

  // advance the control words
  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctrl    <= '0;
      p_ctrl    <= '0;
      t_done    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_ctrl    <= r_ctrl;
      p_ctrl    <= m_ctrl;
      t_done    <= p_ctrl.valid && p_ctrl.last_part && p_ctrl.last_term;
      out_valid <= t_done;
    end
  end

  // multiply, assemble the product, sum the terms, load the output word
  always_ff @(posedge clk) begin
    if (en) begin
      pp   <= r_ctrl.raw ? raw_sum : mul_res;
      m_sh <= sh_sel;
      if (m_ctrl.valid) begin
        prod_acc <= (m_ctrl.first_part ? PROD_W'(0) : prod_acc) + pp_shifted;
      end
      if (p_ctrl.valid && p_ctrl.last_part) begin
        elem_acc <= (p_ctrl.first_term ? ACC_W'(0) : elem_acc)
                  + {{(ACC_W-PROD_W){term[PROD_W-1]}}, term};
        t_elem   <= p_ctrl.elem;
        t_last   <= p_ctrl.last_elem;
      end
      if (t_done) begin
        out_value <= ov_ext[31:0];
        out_index <= t_elem;
        out_last  <= t_last;
      end
    end
  end

  a_idle_no_word: assert property (@(posedge clk) disable iff (rst)
    (!stat.hold && !stat.busy) |=> !out_valid)
    else $error("result word appeared with nothing in flight");

  a_elem_done: assert property (@(posedge clk) disable iff (rst)
    (p_ctrl.valid && p_ctrl.last_part && p_ctrl.last_term && !stat.hold) |=> t_done)
    else $error("final term of an element did not complete it");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value)
                                  && $stable(out_index) && $stable(out_last)))
    else $error("stalled result word changed");

endmodule

// ----- rtl/matrix4x4_fixed_point_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_fixed_point_unit: 4x4 fixed-point matrix engine
// Holds matrices A and B, serves element writes and reads of A, and streams the
// results of B*A, A+B, k*A and the transform of B[0..3] by A.
// ----------------------------------------------------------------------------
// One request word is taken at a time; in_stall stays high until its work has
// left the datapath. A write is stored as it is taken. Every other request
// issues work to the single shared datapath, with its one multiplier, at one
// slot per cycle while the output is not stalled, with P = 1 partial products
// per fixed-point product for DATA_WIDTH up to 32 and P = 4 above. Read A
// issues 1 slot, add 16, scale 16*P, vector transform 16*P and multiply 64*P;
// the next request can be taken in the cycle the last result word appears.
// Add therefore delivers one result word per cycle when not stalled; a Q16.16
// multiply needs a slot for each of the four terms of a dot product, sharing
// the one multiplier. A stalled output word freezes the whole datapath.
// ----------------------------------------------------------------------------
module matrix4x4_fixed_point_unit #(
  parameter int DATA_WIDTH = m4fx_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m4fx_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] scale_factor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_index,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  localparam int DW     = DATA_WIDTH;
  localparam int NP     = (DW > 32) ? 2 : 1;
  localparam int NPARTS = NP * NP;
  localparam int SIN_W  = ((DW > 32) ? DW : 32) + 1;

  localparam logic signed [SIN_W-1:0] IN_MAX = {{(SIN_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SIN_W-1:0] IN_MIN = {{(SIN_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // clamp an incoming 32-bit value into the storage format
  function automatic logic [DW-1:0] sat_in(input logic signed [31:0] x);
    logic signed [SIN_W-1:0] v;
    logic [DW-1:0]           r;
    v = {{(SIN_W-32){x[31]}}, x};
    priority if (v > IN_MAX) begin
      r = IN_MAX[DW-1:0];
    end else if (v < IN_MIN) begin
      r = IN_MIN[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  logic [DW-1:0] mat_a [16];
  logic [DW-1:0] mat_b [16];

  m4fx_pkg::state_t state, state_next;
  m4fx_pkg::req_t   op;
  logic [DW-1:0]    kval;
  logic [3:0]       elem, elem_next;
  logic [1:0]       term, term_next;
  logic [1:0]       part, part_next;

  m4fx_pkg::ctrl_t  iss, r_ctrl;
  m4fx_pkg::stat_t  stat;
  logic [3:0]       addr_a, addr_b;
  logic             use_k;
  logic [DW-1:0]    rd_a, rd_b;

  logic accept, adv, starts_run;
  logic is_mul, is_vec, is_add, is_scale, is_read, raw_op;
  logic last_part, last_term, last_elem;

  assign in_stall = (state != m4fx_pkg::ST_IDLE) || r_ctrl.valid || stat.busy;
  assign accept   = in_valid && !in_stall;
  assign adv      = !stat.hold || (state == m4fx_pkg::ST_IDLE);

  assign starts_run = (req_type == 3'(m4fx_pkg::REQ_MUL))
                   || (req_type == 3'(m4fx_pkg::REQ_ADD))
                   || (req_type == 3'(m4fx_pkg::REQ_SCALE))
                   || (req_type == 3'(m4fx_pkg::REQ_VEC))
                   || (req_type == 3'(m4fx_pkg::REQ_RD_A));

  assign is_mul   = (op == m4fx_pkg::REQ_MUL);
  assign is_vec   = (op == m4fx_pkg::REQ_VEC);
  assign is_add   = (op == m4fx_pkg::REQ_ADD);
  assign is_scale = (op == m4fx_pkg::REQ_SCALE);
  assign is_read  = (op == m4fx_pkg::REQ_RD_A);
  assign raw_op   = is_add || is_read;

  assign last_part = raw_op || (part == 2'(NPARTS - 1));
  assign last_term = !(is_mul || is_vec) || (term == 2'd3);
  assign last_elem = is_read || (is_vec ? (elem == 4'd3) : (elem == 4'd15));

  // operand addresses for the current slot
  always_comb begin
    use_k = is_scale;
    priority if (is_mul) begin
      addr_a = {term, elem[1:0]};
      addr_b = {elem[3:2], term};
    end else if (is_vec) begin
      addr_a = {term, elem[1:0]};
      addr_b = {2'd0, term};
    end else begin
      addr_a = elem;
      addr_b = elem;
    end
  end

  // sequencer: next state and the slot to issue
  always_comb begin
    state_next = state;
    elem_next  = elem;
    term_next  = term;
    part_next  = part;
    iss        = '0;
    unique case (state)
      m4fx_pkg::ST_IDLE: begin
        if (accept && starts_run) begin
          state_next = m4fx_pkg::ST_RUN;
          elem_next  = (req_type == 3'(m4fx_pkg::REQ_RD_A)) ? elem_index : 4'd0;
          term_next  = 2'd0;
          part_next  = 2'd0;
        end
      end
      m4fx_pkg::ST_RUN: begin
        iss.valid      = 1'b1;
        iss.ka         = part[0] && (NP == 2);
        iss.kb         = part[1] && (NP == 2);
        iss.raw        = raw_op;
        iss.add_b      = is_add;
        iss.first_part = (part == 2'd0);
        iss.last_part  = last_part;
        iss.first_term = (term == 2'd0);
        iss.last_term  = last_term;
        iss.elem       = elem;
        iss.last_elem  = last_elem;
        if (last_part) begin
          part_next = 2'd0;
          if (last_term) begin
            term_next = 2'd0;
            if (last_elem) begin
              state_next = m4fx_pkg::ST_IDLE;
              elem_next  = 4'd0;
            end else begin
              elem_next = elem + 4'd1;
            end
          end else begin
            term_next = term + 2'd1;
          end
        end else begin
          part_next = part + 2'd1;
        end
      end
      default: begin
        state_next = m4fx_pkg::ST_IDLE;
      end
    endcase
  end

  // hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4fx_pkg::ST_IDLE;
      elem  <= 4'd0;
      term  <= 2'd0;
      part  <= 2'd0;
    end else if (adv) begin
      state <= state_next;
      elem  <= elem_next;
      term  <= term_next;
      part  <= part_next;
    end
  end

  // latch the request and its scale factor
  always_ff @(posedge clk) begin
    if (accept && starts_run) begin
      op   <= m4fx_pkg::req_t'(req_type);
      kval <= sat_in(scale_factor);
    end
  end

  // matrix storage: element writes, registered operand reads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        mat_a[k] <= '0;
        mat_b[k] <= '0;
      end
    end else if (accept) begin
      if (req_type == 3'(m4fx_pkg::REQ_WR_A)) begin
        mat_a[elem_index] <= sat_in(elem_value);
      end
      if (req_type == 3'(m4fx_pkg::REQ_WR_B)) begin
        mat_b[elem_index] <= sat_in(elem_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stat.hold) begin
      rd_a <= mat_a[addr_a];
      rd_b <= use_k ? kval : mat_b[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ctrl <= '0;
    end else if (!stat.hold) begin
      r_ctrl <= iss;
    end
  end

  m4fx_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .r_ctrl    (r_ctrl),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .out_value (out_value),
    .out_last  (out_last)
  );

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && starts_run) |=> (state == m4fx_pkg::ST_RUN))
    else $error("accepted operation did not start the sequencer");

  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == m4fx_pkg::ST_RUN) |-> in_stall)
    else $error("input taken while an operation is issuing");

  a_raw_one_part: assert property (@(posedge clk) disable iff (rst)
    (r_ctrl.valid && r_ctrl.raw) |-> (r_ctrl.first_part && r_ctrl.last_part))
    else $error("pass-through slot split into partial products");

endmodule

// ----- dv/matrix4x4_fixed_point_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_fixed_point_unit_tb: self-checking bench for the 4x4 matrix unit
// Drives element writes, reads and whole-matrix operations through the
// valid/stall request port. A scoreboard keeps its own copy of A and B,
// predicts every result word in Q16.16 with saturation, and checks the
// output stream in order. Both ports idle at random, with a calm stretch.
// ----------------------------------------------------------------------------
module matrix4x4_fixed_point_unit_tb;

  // selector with no request behind it
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam int FRAC         = 16;
  localparam int RANDOM_ITEMS = 480;
  localparam int MAX_QUIET    = 4000;
  localparam int TAIL_CYCLES  = 40;

  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ZERO    = 32'sh0000_0000;
  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF    = 32'sh0000_8000;
  localparam logic signed [31:0] Q_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [31:0] Q_NEG_ULP = 32'shFFFF_FFFF;

  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [2:0]         req_type     = m4fx_pkg::REQ_WR_A;
  logic [3:0]         elem_index   = 4'd0;
  logic signed [31:0] elem_value   = '0;
  logic signed [31:0] scale_factor = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [3:0]         out_index;
  logic signed [31:0] out_value;
  logic               out_last;

  // no idling on either side while set
  bit calm = 1'b0;
  int quiet_cycles = 0;

  typedef struct packed {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               last;
  } result_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow matrices, predicted word stream, in-order compare
  // --------------------------------------------------------------------------
  class mat_scoreboard;
    logic signed [31:0] mat_a [16];
    logic signed [31:0] mat_b [16];
    result_word_t       due_words [$];
    int                 mismatches;
    int                 words_seen;
    int                 reqs_seen [8];

    function new();
      foreach (mat_a[e]) begin
        mat_a[e] = '0;
        mat_b[e] = '0;
      end
      foreach (reqs_seen[r]) reqs_seen[r] = 0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    // clamp an exact sum to the signed 32-bit range
    function logic signed [31:0] clip(longint v);
      if (v > SAT_HI) return Q_MAX;
      if (v < SAT_LO) return Q_MIN;
      return v[31:0];
    endfunction

    // exact product, then arithmetic shift (floor) of the fraction bits
    function longint qmul(logic signed [31:0] x, logic signed [31:0] y);
      longint prod;
      prod = longint'(x) * longint'(y);
      return prod >>> FRAC;
    endfunction

    function void push_word(int idx, logic signed [31:0] v, bit last);
      result_word_t w;
      w.idx  = idx[3:0];
      w.val  = v;
      w.last = last;
      due_words.push_back(w);
    endfunction

    // update the shadow state and queue the words this request yields
    function void note_request(logic [2:0] req, logic [3:0] idx,
                               logic signed [31:0] val, logic signed [31:0] k);
      longint acc;
      reqs_seen[req]++;
      case (req)
        m4fx_pkg::REQ_WR_A: mat_a[idx] = val;
        m4fx_pkg::REQ_WR_B: mat_b[idx] = val;
        m4fx_pkg::REQ_MUL: begin
          for (int e = 0; e < 16; e++) begin
            acc = 0;
            for (int j = 0; j < 4; j++)
              acc += qmul(mat_b[4 * (e / 4) + j], mat_a[4 * j + (e % 4)]);
            push_word(e, clip(acc), e == 15);
          end
        end
        m4fx_pkg::REQ_ADD: begin
          for (int e = 0; e < 16; e++)
            push_word(e, clip(longint'(mat_a[e]) + longint'(mat_b[e])), e == 15);
        end
        m4fx_pkg::REQ_SCALE: begin
          for (int e = 0; e < 16; e++)
            push_word(e, clip(qmul(mat_a[e], k)), e == 15);
        end
        m4fx_pkg::REQ_VEC: begin
          for (int e = 0; e < 4; e++) begin
            acc = 0;
            for (int j = 0; j < 4; j++)
              acc += qmul(mat_b[j], mat_a[4 * j + e]);
            push_word(e, clip(acc), e == 3);
          end
        end
        m4fx_pkg::REQ_RD_A: push_word(idx, mat_a[idx], 1'b1);
        default: ;
      endcase
    endfunction

    // compare one accepted output word against the oldest prediction
    function void check_word(logic [3:0] idx, logic signed [31:0] v, logic last);
      result_word_t w;
      words_seen++;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word: index %0d value %h last %0b",
                   $realtime, idx, v, last);
        return;
      end
      w = due_words.pop_front();
      if (w.idx !== idx || w.val !== v || w.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: wrong word: expected index %0d value %h last %0b, ",
                    "got index %0d value %h last %0b"},
                   $realtime, w.idx, w.val, w.last, idx, v, last);
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  mat_scoreboard sb = new();

  matrix4x4_fixed_point_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .elem_index   (elem_index),
    .elem_value   (elem_value),
    .scale_factor (scale_factor),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stall the output at random outside the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 20);
  end

  // check accepted words and watch for a hung handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (!rst && out_valid && !out_stall)
      sb.check_word(out_index, out_value, out_last);
    if (quiet_cycles >= MAX_QUIET) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               MAX_QUIET, sb.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // present one request word, hold it until taken, then note it
  task automatic send_word(input logic [2:0] req, input logic [3:0] idx,
                           input logic [31:0] val, input logic [31:0] k);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    elem_index   <= idx;
    elem_value   <= val;
    scale_factor <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, idx, val, k);
  endtask

  // drop valid and hold off until every predicted word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly small Q16.16 values so sums stay in range, plus full range and corners
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
    if (sel < 85) return $urandom();
    case ($urandom_range(4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return Q_ZERO;
      3:       return Q_NEG_ULP;
      default: return Q_ONE;
    endcase
  endfunction

  function automatic logic [2:0] pick_request();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return m4fx_pkg::REQ_WR_A;
    if (sel < 58) return m4fx_pkg::REQ_WR_B;
    if (sel < 68) return m4fx_pkg::REQ_RD_A;
    if (sel < 75) return m4fx_pkg::REQ_MUL;
    if (sel < 82) return m4fx_pkg::REQ_ADD;
    if (sel < 89) return m4fx_pkg::REQ_SCALE;
    if (sel < 96) return m4fx_pkg::REQ_VEC;
    return REQ_UNUSED;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: corner values, every request, saturation and rounding
    send_word(m4fx_pkg::REQ_WR_A,  4'd0,  Q_MAX,     Q_ZERO);
    send_word(m4fx_pkg::REQ_WR_A,  4'd15, Q_MIN,     Q_ZERO);
    send_word(m4fx_pkg::REQ_WR_A,  4'd5,  Q_ONE,     Q_ZERO);
    send_word(m4fx_pkg::REQ_WR_B,  4'd0,  Q_MAX,     Q_ZERO);
    send_word(m4fx_pkg::REQ_WR_B,  4'd15, Q_MIN,     Q_ZERO);
    send_word(m4fx_pkg::REQ_WR_B,  4'd3,  Q_NEG_ONE, Q_ZERO);
    send_word(m4fx_pkg::REQ_RD_A,  4'd0,  Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_RD_A,  4'd15, Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_ADD,   4'd0,  Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_MUL,   4'd0,  Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_SCALE, 4'd0,  Q_ZERO,    Q_MAX);
    send_word(m4fx_pkg::REQ_SCALE, 4'd0,  Q_ZERO,    Q_MIN);
    send_word(m4fx_pkg::REQ_SCALE, 4'd0,  Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_VEC,   4'd0,  Q_ZERO,    Q_ZERO);
    // unused selector must leave A untouched
    send_word(REQ_UNUSED,          4'd5,  Q_MIN,     Q_MAX);
    send_word(m4fx_pkg::REQ_RD_A,  4'd5,  Q_ZERO,    Q_ZERO);
    // smallest negative value times one half floors toward minus infinity
    send_word(m4fx_pkg::REQ_WR_A,  4'd10, Q_NEG_ULP, Q_ZERO);
    send_word(m4fx_pkg::REQ_SCALE, 4'd0,  Q_ZERO,    Q_HALF);
    send_word(m4fx_pkg::REQ_WR_B,  4'd1,  Q_HALF,    Q_ZERO);
    send_word(m4fx_pkg::REQ_VEC,   4'd0,  Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_MUL,   4'd0,  Q_ZERO,    Q_ZERO);
    send_word(m4fx_pkg::REQ_ADD,   4'd0,  Q_ZERO,    Q_ZERO);

    // random: noisy, then calm, then noisy again
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 160 && n < 320);
      if (n == 100 || n == 400) drain_results();
      send_word(pick_request(), 4'($urandom_range(15)), pick_value(), pick_value());
    end
    calm = 1'b0;

    // wait out the remaining words and a tail for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests: %0d writes, %0d reads, %0d mul, %0d add, %0d scale, %0d vec",
             sb.reqs_seen[m4fx_pkg::REQ_WR_A] + sb.reqs_seen[m4fx_pkg::REQ_WR_B],
             sb.reqs_seen[m4fx_pkg::REQ_RD_A], sb.reqs_seen[m4fx_pkg::REQ_MUL],
             sb.reqs_seen[m4fx_pkg::REQ_ADD], sb.reqs_seen[m4fx_pkg::REQ_SCALE],
             sb.reqs_seen[m4fx_pkg::REQ_VEC]);
    $display("unused selectors: %0d, result words checked: %0d, wrong or unexpected: %0d",
             sb.reqs_seen[REQ_UNUSED], sb.words_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
